[design/dpfl_pkg.sv]
// ----------------------------------------------------------------------------
// dpfl_pkg
// Shared constants, state, command and status types for the distinct prime factor
// lister: controller and datapath.
// ----------------------------------------------------------------------------
package dpfl_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int FIELD_BITS  = 16;
    // working width: the field is cut to the low VW bits, the smaller of VALUE_BITS and FIELD_BITS
    localparam int VW          = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int SQ_W        = VW + 2;
    localparam int CNT_W       = $clog2(VW + 1);
    localparam int MAX_RESULTS = 6;
    localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_TEST,
        ST_DIV,
        ST_POST
    } state_t;

    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_DIV,
        SEL_REM
    } sel_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic rem_update;
        logic next_cand;
        logic emit;
        sel_t sel;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic below_two;
        logic cand_ok;
        logic tail_emit;
        logic rem_zero;
        logic hit;
        logic div_busy;
        logic out_free;
        logic d_last;
    } status_t;

endpackage

[design/distinct_prime_factor_lister_unit.sv]
// one number at a time; the next word is taken once the last result is in the output register
// words below two give only the no-factor word; else each candidate d (2 .. sqrt of the cofactor)
// gets a test step and a division, with one extra division per power of d
// reset clears the sequencer, the divider count, the factor count, the hit flag and the valid
// ----------------------------------------------------------------------------
// distinct_prime_factor_lister_unit
// Emits the distinct prime factors of each input word in ascending order,
// the final one marked last; words below two give a single no-factor word.
// ----------------------------------------------------------------------------
module distinct_prime_factor_lister_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              src_valid,
    output logic                              src_stall,
    input  logic [dpfl_pkg::FIELD_BITS-1:0]   value_in,
    output logic                              dst_valid,
    input  logic                              dst_stall,
    output logic [dpfl_pkg::FIELD_BITS-1:0]   factor,
    output logic                              is_last,
    output logic                              no_factor
);

    dpfl_pkg::cmd_t    cmd;
    dpfl_pkg::status_t st;

    dpfl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .st        (st),
        .cmd       (cmd)
    );

    dpfl_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value_in  (value_in),
        .cmd       (cmd),
        .st        (st),
        .dst_stall (dst_stall),
        .dst_valid (dst_valid),
        .factor    (factor),
        .is_last   (is_last),
        .no_factor (no_factor)
    );

    // a no-factor word is always the only word: marked last, with a zero factor
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && no_factor |-> is_last && (factor == '0))
        else $error("no-factor word not marked last or nonzero");

    // a started division keeps the divider busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> st.div_busy)
        else $error("divider did not start");

    // new words are only taken while the divider is quiet
    assert property (@(posedge clk) disable iff (!rst_n)
        !src_stall |-> !st.div_busy)
        else $error("input taken during a division");

    // emission never overwrites a word still waiting downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("output word overwritten");

endmodule

[design/dpfl_datapath.sv]
// ----------------------------------------------------------------------------
// dpfl_datapath
// Working value, candidate divisor and its square, a bit-serial restoring
// divider, the factor count and the output word register.
// ----------------------------------------------------------------------------
module dpfl_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [dpfl_pkg::FIELD_BITS-1:0]   value_in,
    input  dpfl_pkg::cmd_t                    cmd,
    output dpfl_pkg::status_t                 st,
    input  logic                              dst_stall,
    output logic                              dst_valid,
    output logic [dpfl_pkg::FIELD_BITS-1:0]   factor,
    output logic                              is_last,
    output logic                              no_factor
);

    logic [dpfl_pkg::VW-1:0]          rem_reg,    rem_next;
    logic [dpfl_pkg::VW-1:0]          d_reg,      d_next;
    logic [dpfl_pkg::SQ_W-1:0]        dsq_reg,    dsq_next;
    logic [dpfl_pkg::VW-1:0]          quo_reg,    quo_next;
    logic [dpfl_pkg::VW-1:0]          part_reg,   part_next;
    logic [dpfl_pkg::CNT_W-1:0]       cnt_reg,    cnt_next;
    logic [dpfl_pkg::NCNT_W-1:0]      n_reg,      n_next;
    logic                             hit_reg,    hit_next;
    logic                             valid_reg,  valid_next;
    logic [dpfl_pkg::FIELD_BITS-1:0]  factor_reg, factor_next;
    logic                             last_reg,   last_next;
    logic                             none_reg,   none_next;

    logic [dpfl_pkg::VW:0]            shifted;
    logic [dpfl_pkg::VW:0]            diff;
    logic                             ge;

    // one quotient bit per cycle
    always_comb
    begin
        shifted = {part_reg, quo_reg[dpfl_pkg::VW-1]};
        ge      = (shifted >= {1'b0, d_reg});
        diff    = shifted - {1'b0, d_reg};
    end

    always_comb
    begin
        rem_next    = rem_reg;
        d_next      = d_reg;
        dsq_next    = dsq_reg;
        quo_next    = quo_reg;
        part_next   = part_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        hit_next    = hit_reg;
        valid_next  = valid_reg;
        factor_next = factor_reg;
        last_next   = last_reg;
        none_next   = none_reg;

        if (cmd.load)
        begin
            rem_next = value_in[dpfl_pkg::VW-1:0];
            d_next   = dpfl_pkg::VW'(2);
            dsq_next = dpfl_pkg::SQ_W'(4);
            n_next   = '0;
            hit_next = 1'b0;
        end

        if (cmd.rem_update)
        begin
            rem_next = quo_reg;
            hit_next = 1'b1;
        end

        if (cmd.div_start)
        begin
            quo_next  = cmd.rem_update ? quo_reg : rem_reg;
            part_next = '0;
            cnt_next  = dpfl_pkg::CNT_W'(dpfl_pkg::VW);
        end
        else if (cnt_reg != '0)
        begin
            part_next = ge ? diff[dpfl_pkg::VW-1:0] : shifted[dpfl_pkg::VW-1:0];
            quo_next  = {quo_reg[dpfl_pkg::VW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
        end

        // (d+1)^2 = d^2 + 2d + 1
        if (cmd.next_cand)
        begin
            d_next   = d_reg + 1'b1;
            dsq_next = dsq_reg + dpfl_pkg::SQ_W'({d_reg, 1'b1});
        end

        if (cmd.emit)
        begin
            valid_next = 1'b1;
            last_next  = cmd.last;
            none_next  = (cmd.sel == dpfl_pkg::SEL_NONE);
            unique case (cmd.sel)
                dpfl_pkg::SEL_DIV:
                begin
                    factor_next = dpfl_pkg::FIELD_BITS'(d_reg);
                    n_next      = n_reg + 1'b1;
                    hit_next    = 1'b0;
                end
                dpfl_pkg::SEL_REM:  factor_next = dpfl_pkg::FIELD_BITS'(rem_reg);
                default:            factor_next = '0;
            endcase
        end
        else if (!dst_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            n_reg     <= '0;
            hit_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            hit_reg   <= hit_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        d_reg      <= d_next;
        dsq_reg    <= dsq_next;
        quo_reg    <= quo_next;
        part_reg   <= part_next;
        factor_reg <= factor_next;
        last_reg   <= last_next;
        none_reg   <= none_next;
    end

    always_comb
    begin
        st.below_two = (rem_reg < dpfl_pkg::VW'(2));
        st.cand_ok   = (dsq_reg <= dpfl_pkg::SQ_W'(rem_reg)) &&
                       (n_reg < dpfl_pkg::NCNT_W'(dpfl_pkg::MAX_RESULTS));
        st.tail_emit = (rem_reg > dpfl_pkg::VW'(1)) &&
                       (n_reg < dpfl_pkg::NCNT_W'(dpfl_pkg::MAX_RESULTS));
        st.rem_zero  = (part_reg == '0);
        st.hit       = hit_reg;
        st.div_busy  = (cnt_reg != '0);
        st.out_free  = !valid_reg || !dst_stall;
        // nothing left once this divisor is out, or this word fills the list
        st.d_last    = (rem_reg == dpfl_pkg::VW'(1)) ||
                       (n_reg == dpfl_pkg::NCNT_W'(dpfl_pkg::MAX_RESULTS - 1));
    end

    assign dst_valid = valid_reg;
    assign factor    = factor_reg;
    assign is_last   = last_reg;
    assign no_factor = none_reg;

endmodule

[design/dpfl_ctrl.sv]
// ----------------------------------------------------------------------------
// dpfl_ctrl
// Sequencer for trial division: tests each candidate, repeats the division
// while it divides evenly, and schedules the output words.
// ----------------------------------------------------------------------------
module dpfl_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  dpfl_pkg::status_t  st,
    output dpfl_pkg::cmd_t     cmd
);

    dpfl_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dpfl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.div_start  = 1'b0;
        cmd.rem_update = 1'b0;
        cmd.next_cand  = 1'b0;
        cmd.emit       = 1'b0;
        cmd.sel        = dpfl_pkg::SEL_NONE;
        cmd.last       = 1'b0;
        src_stall      = (state_reg != dpfl_pkg::ST_IDLE);

        unique case (state_reg)
            dpfl_pkg::ST_IDLE:
            begin
                if (src_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dpfl_pkg::ST_START;
                end
            end
            dpfl_pkg::ST_START:
            begin
                if (!st.below_two)
                begin
                    state_next = dpfl_pkg::ST_TEST;
                end
                else if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = dpfl_pkg::SEL_NONE;
                    cmd.last   = 1'b1;
                    state_next = dpfl_pkg::ST_IDLE;
                end
            end
            dpfl_pkg::ST_TEST:
            begin
                if (st.cand_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = dpfl_pkg::ST_DIV;
                end
                else if (!st.tail_emit)
                begin
                    state_next = dpfl_pkg::ST_IDLE;
                end
                else if (st.out_free)
                begin
                    // leftover cofactor is prime
                    cmd.emit   = 1'b1;
                    cmd.sel    = dpfl_pkg::SEL_REM;
                    cmd.last   = 1'b1;
                    state_next = dpfl_pkg::ST_IDLE;
                end
            end
            dpfl_pkg::ST_DIV:
            begin
                if (!st.div_busy)
                begin
                    state_next = dpfl_pkg::ST_POST;
                end
            end
            dpfl_pkg::ST_POST:
            begin
                if (st.rem_zero)
                begin
                    // divides evenly: keep the quotient and divide again
                    cmd.rem_update = 1'b1;
                    cmd.div_start  = 1'b1;
                    state_next     = dpfl_pkg::ST_DIV;
                end
                else if (!st.hit)
                begin
                    cmd.next_cand = 1'b1;
                    state_next    = dpfl_pkg::ST_TEST;
                end
                else if (st.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.sel       = dpfl_pkg::SEL_DIV;
                    cmd.last      = st.d_last;
                    cmd.next_cand = 1'b1;
                    state_next    = dpfl_pkg::ST_TEST;
                end
            end
            default:
            begin
                state_next = dpfl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
